// ===== src/mecip_pkg.sv =====
// Package: constants, status codes and curve table for the Mach/elongation interpolator.
package mecip_pkg;

   localparam int CurvePointsDefault = 17;
   localparam int FracBitsDefault    = 8;
   localparam int RomPoints          = 17;
   localparam int RomCurves          = 5;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NEG_ARG  = 2'd1,
      STATUS_ZERO_NOSE = 2'd2
   } status_type;

   localparam logic [1:0] ARG_NONE = 2'd0;
   localparam logic [1:0] ARG_MACH = 2'd1;
   localparam logic [1:0] ARG_NOSE = 2'd2;
   localparam logic [1:0] ARG_BODY = 2'd3;

   function automatic logic [15:0] curve_rom(input logic [2:0] c, input logic [4:0] p);
      logic [15:0] v;
      v = 16'd0;
      case ({c, p})
         {3'd0, 5'd0}: v = 16'd2894;  {3'd0, 5'd1}: v = 16'd3277;
         {3'd0, 5'd2}: v = 16'd4021;  {3'd0, 5'd3}: v = 16'd4917;
         {3'd0, 5'd4}: v = 16'd6179;  {3'd0, 5'd5}: v = 16'd7504;
         {3'd0, 5'd6}: v = 16'd8475;  {3'd0, 5'd7}: v = 16'd8938;
         {3'd0, 5'd8}: v = 16'd9108;  {3'd0, 5'd9}: v = 16'd9230;
         {3'd0, 5'd10}: v = 16'd9284; {3'd0, 5'd11}: v = 16'd9303;
         {3'd0, 5'd12}: v = 16'd9100; {3'd0, 5'd13}: v = 16'd8703;
         {3'd0, 5'd14}: v = 16'd8264; {3'd0, 5'd15}: v = 16'd7776;
         {3'd0, 5'd16}: v = 16'd7230;
         {3'd1, 5'd0}: v = 16'd2894;  {3'd1, 5'd1}: v = 16'd3277;
         {3'd1, 5'd2}: v = 16'd4021;  {3'd1, 5'd3}: v = 16'd4917;
         {3'd1, 5'd4}: v = 16'd6283;  {3'd1, 5'd5}: v = 16'd8516;
         {3'd1, 5'd6}: v = 16'd11664; {3'd1, 5'd7}: v = 16'd14847;
         {3'd1, 5'd8}: v = 16'd16703; {3'd1, 5'd9}: v = 16'd17487;
         {3'd1, 5'd10}: v = 16'd17745; {3'd1, 5'd11}: v = 16'd17771;
         {3'd1, 5'd12}: v = 16'd17771; {3'd1, 5'd13}: v = 16'd17771;
         {3'd1, 5'd14}: v = 16'd17771; {3'd1, 5'd15}: v = 16'd17771;
         {3'd1, 5'd16}: v = 16'd17771;
         {3'd2, 5'd0}: v = 16'd2894;  {3'd2, 5'd1}: v = 16'd3277;
         {3'd2, 5'd2}: v = 16'd4021;  {3'd2, 5'd3}: v = 16'd4917;
         {3'd2, 5'd4}: v = 16'd6283;  {3'd2, 5'd5}: v = 16'd8516;
         {3'd2, 5'd6}: v = 16'd11753; {3'd2, 5'd7}: v = 16'd16332;
         {3'd2, 5'd8}: v = 16'd21557; {3'd2, 5'd9}: v = 16'd26420;
         {3'd2, 5'd10}: v = 16'd29646; {3'd2, 5'd11}: v = 16'd31770;
         {3'd2, 5'd12}: v = 16'd33231; {3'd2, 5'd13}: v = 16'd34427;
         {3'd2, 5'd14}: v = 16'd35267; {3'd2, 5'd15}: v = 16'd35853;
         {3'd2, 5'd16}: v = 16'd36325;
         {3'd3, 5'd0}: v = 16'd2894;  {3'd3, 5'd1}: v = 16'd3277;
         {3'd3, 5'd2}: v = 16'd4021;  {3'd3, 5'd3}: v = 16'd4917;
         {3'd3, 5'd4}: v = 16'd6283;  {3'd3, 5'd5}: v = 16'd8516;
         {3'd3, 5'd6}: v = 16'd11753; {3'd3, 5'd7}: v = 16'd16332;
         {3'd3, 5'd8}: v = 16'd21557; {3'd3, 5'd9}: v = 16'd26926;
         {3'd3, 5'd10}: v = 16'd31683; {3'd3, 5'd11}: v = 16'd35387;
         {3'd3, 5'd12}: v = 16'd37899; {3'd3, 5'd13}: v = 16'd39718;
         {3'd3, 5'd14}: v = 16'd41174; {3'd3, 5'd15}: v = 16'd42418;
         {3'd3, 5'd16}: v = 16'd43661;
         {3'd4, 5'd0}: v = 16'd2894;  {3'd4, 5'd1}: v = 16'd3277;
         {3'd4, 5'd2}: v = 16'd4021;  {3'd4, 5'd3}: v = 16'd4917;
         {3'd4, 5'd4}: v = 16'd6283;  {3'd4, 5'd5}: v = 16'd8516;
         {3'd4, 5'd6}: v = 16'd11753; {3'd4, 5'd7}: v = 16'd16332;
         {3'd4, 5'd8}: v = 16'd21557; {3'd4, 5'd9}: v = 16'd27021;
         {3'd4, 5'd10}: v = 16'd32389; {3'd4, 5'd11}: v = 16'd36696;
         {3'd4, 5'd12}: v = 16'd40300; {3'd4, 5'd13}: v = 16'd43129;
         {3'd4, 5'd14}: v = 16'd45395; {3'd4, 5'd15}: v = 16'd47191;
         {3'd4, 5'd16}: v = 16'd48759;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/mach_elongation_coeff_interp_core.sv =====
// Top level: Mach/elongation coefficient interpolator, fully pipelined.
//
// One request is accepted every cycle while the output is not stalled; each
// produces exactly one response. The 47 registers between the request and
// rsp_tvalid are: the check stage (1), the pipelined square root with its
// input register (17, one result bit per stage), the two bit-per-stage
// dividers for x2 and |x1| running side by side (25), and four interpolation
// stages. The whole pipeline advances together, so backpressure on rsp_tready
// freezes every stage and nothing is lost or repeated. Errors (negative
// argument, zero nose elongation) flow through the same pipeline and come out
// with zeroed data fields.
module mach_elongation_coeff_interp_core #(
   parameter int CURVE_POINTS = mecip_pkg::CurvePointsDefault,
   parameter int FRAC_BITS    = mecip_pkg::FracBitsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // mach[15:0], nose_elong[31:16], body_elong[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata   // coefficient, ratio_raw, axis_raw, status, bad_arg, pad
);
   import mecip_pkg::*;

   localparam int One   = 1 << FRAC_BITS;
   // |M^2 - 1|: M^2 < 2^30, one is 2^(2*FRAC_BITS); width kept even
   localparam int SqW   = (2 * FRAC_BITS + 2 > 32) ? 2 * FRAC_BITS + 2 : 32;
   localparam int SqSt  = SqW / 2;          // isqrt steps, also root width
   localparam int DivW  = SqSt + FRAC_BITS; // numerator width for both divides
   localparam int TagW  = 5;                // pos, status, bad
   localparam logic [SqW-1:0] OneSq = SqW'(1) << (2 * FRAC_BITS);

   logic advance;
   assign advance   = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // ---- stage A: checks, M^2 ----
   logic signed [15:0] m_in, ln_in, lc_in;
   assign m_in  = req_tdata[15:0];
   assign ln_in = req_tdata[31:16];
   assign lc_in = req_tdata[47:32];

   logic [1:0]  a_status_in, a_bad_in;
   always_comb begin
      a_status_in = STATUS_OK; a_bad_in = ARG_NONE;
      if (m_in < 0)       begin a_status_in = STATUS_NEG_ARG;   a_bad_in = ARG_MACH; end
      else if (ln_in < 0) begin a_status_in = STATUS_NEG_ARG;   a_bad_in = ARG_NOSE; end
      else if (lc_in < 0) begin a_status_in = STATUS_NEG_ARG;   a_bad_in = ARG_BODY; end
      else if (ln_in == 0) begin a_status_in = STATUS_ZERO_NOSE; a_bad_in = ARG_NOSE; end
   end

   logic        a_vld_ff;
   logic [1:0]  a_status_ff, a_bad_ff;
   logic [14:0] a_m_ff, a_ln_ff, a_lc_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         a_status_ff <= a_status_in; a_bad_ff <= a_bad_in;
         a_m_ff  <= m_in[14:0];
         a_ln_ff <= (a_status_in == STATUS_OK) ? ln_in[14:0] : 15'd1;
         a_lc_ff <= lc_in[14:0];
      end
      if (reset) a_vld_ff <= 1'b0;
      else if (advance) a_vld_ff <= req_tvalid;
   end

   logic [29:0] msq_in;
   logic [SqW-1:0] d_in;
   logic        pos_in;
   assign msq_in = a_m_ff * a_m_ff;
   assign pos_in = {15'd0, a_m_ff} >= 30'(One);
   assign d_in   = pos_in ? SqW'(msq_in) - OneSq
                          : OneSq - SqW'(msq_in);

   // ---- isqrt pipeline, bit-pair per stage; ln, lc, status ride along ----
   logic [SqW-1:0] sv_ff [SqSt+1];
   logic [SqW-1:0] sr_ff [SqSt+1];
   logic [14:0]    sln_ff [SqSt+1], slc_ff [SqSt+1];
   logic [1:0]     sst_ff [SqSt+1], sbd_ff [SqSt+1];
   logic           spos_ff [SqSt+1], svld_ff [SqSt+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         sv_ff[0] <= d_in; sr_ff[0] <= '0;
         sln_ff[0] <= a_ln_ff; slc_ff[0] <= a_lc_ff;
         sst_ff[0] <= a_status_ff; sbd_ff[0] <= a_bad_ff; spos_ff[0] <= pos_in;
      end
      if (reset) svld_ff[0] <= 1'b0;
      else if (advance) svld_ff[0] <= a_vld_ff;
   end

   for (genvar k = 0; k < SqSt; k++) begin : g_sqrt
      localparam logic [SqW-1:0] Bit = SqW'(1) << (SqW - 2 - 2 * k);
      logic [SqW-1:0] t_in;
      assign t_in = sr_ff[k] + Bit;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (sv_ff[k] >= t_in) begin
               sv_ff[k+1] <= sv_ff[k] - t_in;
               sr_ff[k+1] <= (sr_ff[k] >> 1) + Bit;
            end else begin
               sv_ff[k+1] <= sv_ff[k];
               sr_ff[k+1] <= sr_ff[k] >> 1;
            end
            sln_ff[k+1] <= sln_ff[k]; slc_ff[k+1] <= slc_ff[k];
            sst_ff[k+1] <= sst_ff[k]; sbd_ff[k+1] <= sbd_ff[k];
            spos_ff[k+1] <= spos_ff[k];
         end
         if (reset) svld_ff[k+1] <= 1'b0;
         else if (advance) svld_ff[k+1] <= svld_ff[k];
      end
   end

   // ---- two dividers in lockstep ----
   logic [SqSt-1:0] s_root;
   assign s_root = sr_ff[SqSt][SqSt-1:0];

   logic [DivW-1:0] num1_in, num2_in, q1, q2;
   assign num1_in = {{(DivW-SqSt){1'b0}}, s_root} << FRAC_BITS;
   assign num2_in = {{(DivW-15){1'b0}}, slc_ff[SqSt]} << FRAC_BITS;

   logic [TagW-1:0] tag_in, tag_out, tag_x2;
   assign tag_in = {spos_ff[SqSt], sst_ff[SqSt], sbd_ff[SqSt]};
   logic v1, v2;

   mecip_div_pipe #(.NumW(DivW), .DenW(15), .TagW(TagW)) u_div_x1 (
      .clock, .reset, .advance,
      .in_valid(svld_ff[SqSt]), .in_num(num1_in), .in_den(sln_ff[SqSt]),
      .in_tag(tag_in), .out_valid(v1), .out_quot(q1), .out_tag(tag_out));
   mecip_div_pipe #(.NumW(DivW), .DenW(15), .TagW(TagW)) u_div_x2 (
      .clock, .reset, .advance,
      .in_valid(svld_ff[SqSt]), .in_num(num2_in), .in_den(sln_ff[SqSt]),
      .in_tag(tag_in), .out_valid(v2), .out_quot(q2), .out_tag(tag_x2));

   logic [1:0] d_st, d_bd;
   logic       d_pos;
   assign {d_pos, d_st, d_bd} = tag_out;

   // ---- stage B: saturate raws, grid positions ----
   localparam int UW = DivW + 4;
   logic signed [UW-1:0] x1_in, u_in;
   logic [15:0] ratio_in, axis_in;
   logic [4:0]  idx_in; logic [FRAC_BITS:0] wx_in;
   logic [2:0]  c_in;   logic [FRAC_BITS:0] wy_in;
   logic [DivW-1:0] x2c;
   always_comb begin
      x1_in = d_pos ? UW'(q1) : -UW'(q1);
      ratio_in = (q2 > DivW'(65535)) ? 16'hFFFF : q2[15:0];
      if (x1_in > UW'(32767)) axis_in = 16'h7FFF;
      else if (x1_in < -UW'(32768)) axis_in = 16'h8000;
      else axis_in = x1_in[15:0];
      u_in = UW'(5) * x1_in + UW'(4 * One);
      if (u_in > UW'((CURVE_POINTS - 1) * One)) u_in = UW'((CURVE_POINTS - 1) * One);
      if (u_in < UW'(One)) u_in = UW'(One);
      if ((u_in >>> FRAC_BITS) >= UW'(RomPoints - 1)) begin
         idx_in = 5'(RomPoints - 2); wx_in = (FRAC_BITS+1)'(One);
      end else begin
         idx_in = 5'(u_in >>> FRAC_BITS);
         wx_in  = {1'b0, u_in[FRAC_BITS-1:0]};
      end
      x2c = q2;
      if (x2c < DivW'(One / 2)) x2c = DivW'(One / 2);
      if (x2c > DivW'(4 * One)) x2c = DivW'(4 * One);
      if (x2c < DivW'(One)) begin
         c_in = 3'd0; wy_in = (FRAC_BITS+1)'(2 * x2c - DivW'(One));
      end else if ((x2c >> FRAC_BITS) >= DivW'(RomCurves - 1)) begin
         c_in = 3'(RomCurves - 2); wy_in = (FRAC_BITS+1)'(One);
      end else begin
         c_in = 3'(x2c >> FRAC_BITS); wy_in = {1'b0, x2c[FRAC_BITS-1:0]};
      end
   end

   logic b_vld_ff;
   logic [1:0] b_st_ff, b_bd_ff;
   logic [15:0] b_ratio_ff, b_axis_ff;
   logic [4:0] b_idx_ff; logic [2:0] b_c_ff;
   logic [FRAC_BITS:0] b_wx_ff, b_wy_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         b_st_ff <= d_st; b_bd_ff <= d_bd;
         b_ratio_ff <= ratio_in; b_axis_ff <= axis_in;
         b_idx_ff <= idx_in; b_c_ff <= c_in; b_wx_ff <= wx_in; b_wy_ff <= wy_in;
      end
      if (reset) b_vld_ff <= 1'b0;
      else if (advance) b_vld_ff <= v1 & v2;
   end

   // ---- stage C: ROM fetch of four corners ----
   logic c_vld_ff;
   logic [1:0] c_st_ff, c_bd_ff;
   logic [15:0] c_ratio_ff, c_axis_ff;
   logic [FRAC_BITS:0] c_wx_ff, c_wy_ff;
   logic [15:0] c_a0_ff, c_a1_ff, c_b0_ff, c_b1_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         c_st_ff <= b_st_ff; c_bd_ff <= b_bd_ff;
         c_ratio_ff <= b_ratio_ff; c_axis_ff <= b_axis_ff;
         c_wx_ff <= b_wx_ff; c_wy_ff <= b_wy_ff;
         c_a0_ff <= curve_rom(b_c_ff, b_idx_ff);
         c_a1_ff <= curve_rom(b_c_ff, b_idx_ff + 5'd1);
         c_b0_ff <= curve_rom(b_c_ff + 3'd1, b_idx_ff);
         c_b1_ff <= curve_rom(b_c_ff + 3'd1, b_idx_ff + 5'd1);
      end
      if (reset) c_vld_ff <= 1'b0;
      else if (advance) c_vld_ff <= b_vld_ff;
   end

   // blend: (a*2^F + (b-a)*w + 2^(F-1)) >> F, values stay within 16 bits
   localparam int BW = 18 + FRAC_BITS + 2;
   function automatic logic [16:0] blend(input logic [16:0] a, input logic [16:0] b,
                                         input logic [FRAC_BITS:0] w);
      logic signed [BW-1:0] acc;
      acc = (BW'(a) <<< FRAC_BITS)
          + (BW'($signed({1'b0, b}) - $signed({1'b0, a})) * $signed({1'b0, w}))
          + BW'(One / 2);
      return 17'(acc >>> FRAC_BITS);
   endfunction

   // ---- stage D: x1 blends ----
   logic d_vld_ff;
   logic [1:0] dd_st_ff, dd_bd_ff;
   logic [15:0] dd_ratio_ff, dd_axis_ff;
   logic [FRAC_BITS:0] dd_wy_ff;
   logic [16:0] ya_ff, yb_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         dd_st_ff <= c_st_ff; dd_bd_ff <= c_bd_ff;
         dd_ratio_ff <= c_ratio_ff; dd_axis_ff <= c_axis_ff; dd_wy_ff <= c_wy_ff;
         ya_ff <= blend({1'b0, c_a0_ff}, {1'b0, c_a1_ff}, c_wx_ff);
         yb_ff <= blend({1'b0, c_b0_ff}, {1'b0, c_b1_ff}, c_wx_ff);
      end
      if (reset) d_vld_ff <= 1'b0;
      else if (advance) d_vld_ff <= c_vld_ff;
   end

   // ---- stage E: x2 blend, output register ----
   logic [16:0] y_in;
   logic ok_in;
   assign y_in  = blend(ya_ff, yb_ff, dd_wy_ff);
   assign ok_in = dd_st_ff == STATUS_OK;

   logic e_vld_ff;
   logic [55:0] e_data_ff;
   always_ff @(posedge clock) begin
      if (advance)
         e_data_ff <= {4'd0, dd_bd_ff, dd_st_ff,
                       ok_in ? dd_axis_ff : 16'd0,
                       ok_in ? dd_ratio_ff : 16'd0,
                       ok_in ? (y_in[16] ? 16'hFFFF : y_in[15:0]) : 16'd0};
      if (reset) e_vld_ff <= 1'b0;
      else if (advance) e_vld_ff <= d_vld_ff;
   end

   assign rsp_tvalid = e_vld_ff;
   assign rsp_tdata  = e_data_ff;

   // ---- checks ----
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed under stall");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49:48] != STATUS_OK |-> rsp_tdata[47:0] == 48'd0)
      else $error("error response carries data");
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      v1 == v2 && (!v1 || tag_out == tag_x2))
      else $error("dividers out of step");
endmodule

// ===== src/mecip_div_pipe.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module mecip_div_pipe #(
   parameter int NumW  = 24,
   parameter int DenW  = 16,
   parameter int TagW  = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic            in_valid,
   input  logic [NumW-1:0] in_num,
   input  logic [DenW-1:0] in_den,
   input  logic [TagW-1:0] in_tag,
   output logic            out_valid,
   output logic [NumW-1:0] out_quot,
   output logic [TagW-1:0] out_tag
);
   // stage k holds remainder, numerator bits still to shift, quotient so far
   logic [NumW-1:0] rem_ff  [NumW+1];
   logic [NumW-1:0] num_ff  [NumW+1];
   logic [DenW-1:0] den_ff  [NumW+1];
   logic [TagW-1:0] tag_ff  [NumW+1];
   logic            vld_ff  [NumW+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0] <= '0;
         num_ff[0] <= in_num;
         den_ff[0] <= in_den;
         tag_ff[0] <= in_tag;
      end
      if (reset) vld_ff[0] <= 1'b0;
      else if (advance) vld_ff[0] <= in_valid;
   end

   for (genvar k = 0; k < NumW; k++) begin : g_stage
      logic [NumW:0]   trial_in;
      logic [NumW:0]   diff_in;
      logic            ge_in;
      always_comb begin
         trial_in = {rem_ff[k], num_ff[k][NumW-1]};
         diff_in  = trial_in - {{(NumW+1-DenW){1'b0}}, den_ff[k]};
         ge_in    = trial_in >= {{(NumW+1-DenW){1'b0}}, den_ff[k]};
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1] <= ge_in ? diff_in[NumW-1:0] : trial_in[NumW-1:0];
            num_ff[k+1] <= {num_ff[k][NumW-2:0], ge_in};
            den_ff[k+1] <= den_ff[k];
            tag_ff[k+1] <= tag_ff[k];
         end
         if (reset) vld_ff[k+1] <= 1'b0;
         else if (advance) vld_ff[k+1] <= vld_ff[k];
      end
   end

   assign out_valid = vld_ff[NumW];
   assign out_quot  = num_ff[NumW];
   assign out_tag   = tag_ff[NumW];
endmodule

// ===== verif/mach_elongation_coeff_interp_core_test.sv =====
// Testbench for the Mach/elongation coefficient interpolator core.
`timescale 1ns / 100ps

module mach_elongation_coeff_interp_core_test;
   import mecip_pkg::*;

   localparam int Frac = 8;
   localparam int One  = 1 << Frac;

   typedef struct packed {
      logic [15:0] coeff;
      logic [15:0] ratio;
      logic [15:0] axis;
      status_type  status;
      logic [1:0]  bad_arg;
   } coeff_result_type;

   typedef struct {
      logic [15:0] mach;
      logic [15:0] nose;
      logic [15:0] body;
      bit          typed;   // expected value given in the row
      coeff_result_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;   // mach, nose_elong, body_elong
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;   // coefficient, ratio_raw, axis_raw, status, bad_arg, pad

   mach_elongation_coeff_interp_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   coeff_result_type pending_results[$];
   stim_row_type     directed_rows[$];
   int            mismatch_count;
   int            requests_sent;
   int            responses_seen;
   int            error_responses;
   bit            long_stall_done;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit: ~1100 requests, worst-case gaps and stalls, plus pipeline.
   initial begin
      #400000;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint lerp_round(input longint a, input longint b, input longint w);
      longint acc;
      acc = a * One + (b - a) * w + (One / 2);
      return acc >>> Frac;
   endfunction

   function automatic longint rom_at(input int c, input longint p);
      return longint'(curve_rom(3'(c), 5'(p)));
   endfunction

   function automatic coeff_result_type predict_coeff(input logic [15:0] mach_in,
                                                      input logic [15:0] nose_in,
                                                      input logic [15:0] body_in);
      coeff_result_type r;
      longint m, ln, lc, x2, x1, mag, u, idx, wx, x2c, wy, ya, yb, y;
      longint unsigned msq, gap, root;
      int curve;
      bit above;
      m  = longint'($signed(mach_in));
      ln = longint'($signed(nose_in));
      lc = longint'($signed(body_in));
      r = '0;
      r.status = STATUS_OK;
      if (m < 0) begin
         r.status = STATUS_NEG_ARG; r.bad_arg = ARG_MACH;
      end else if (ln < 0) begin
         r.status = STATUS_NEG_ARG; r.bad_arg = ARG_NOSE;
      end else if (lc < 0) begin
         r.status = STATUS_NEG_ARG; r.bad_arg = ARG_BODY;
      end else if (ln == 0) begin
         r.status = STATUS_ZERO_NOSE; r.bad_arg = ARG_NOSE;
      end
      if (r.status != STATUS_OK) return r;

      x2 = (lc * One) / ln;
      r.ratio = (x2 > 65535) ? 16'hFFFF : x2[15:0];

      msq = m * m;
      above = (m >= One);
      gap = above ? msq - (One * One) : (One * One) - msq;
      root = int_sqrt(gap);
      mag = longint'((root << Frac) / ln);
      x1 = above ? mag : -mag;
      r.axis = (x1 > 32767) ? 16'h7FFF : (x1 < -32768) ? 16'h8000 : x1[15:0];

      u = 5 * x1 + 4 * One;
      if (u > 16 * One) u = 16 * One;
      if (u < One) u = One;
      idx = u >>> Frac;
      wx = u & (One - 1);
      if (idx >= RomPoints - 1) begin
         idx = RomPoints - 2; wx = One;
      end

      x2c = x2;
      if (x2c < One / 2) x2c = One / 2;
      if (x2c > 4 * One) x2c = 4 * One;
      if (x2c < One) begin
         curve = 0; wy = 2 * x2c - One;
      end else begin
         curve = int'(x2c >>> Frac);
         wy = x2c & (One - 1);
         if (curve >= RomCurves - 1) begin
            curve = RomCurves - 2; wy = One;
         end
      end
      ya = lerp_round(rom_at(curve, idx), rom_at(curve, idx + 1), wx);
      yb = lerp_round(rom_at(curve + 1, idx), rom_at(curve + 1, idx + 1), wx);
      y = lerp_round(ya, yb, wy);
      if (y > 65535) y = 65535;
      r.coeff = y[15:0];
      return r;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch @%0t response %0d: %s got %0d want %0d",
               $time, responses_seen, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      coeff_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.coeff   = rsp_tdata[15:0];
         got.ratio   = rsp_tdata[31:16];
         got.axis    = rsp_tdata[47:32];
         got.status  = status_type'(rsp_tdata[49:48]);
         got.bad_arg = rsp_tdata[51:50];
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response, coeff", got.coeff, 0);
         end else begin
            want = pending_results.pop_front();
            if (got.coeff !== want.coeff) report_mismatch("coefficient", got.coeff, want.coeff);
            if (got.ratio !== want.ratio) report_mismatch("ratio_raw", got.ratio, want.ratio);
            if (got.axis !== want.axis)
               report_mismatch("axis_raw", $signed(got.axis), $signed(want.axis));
            if (got.status !== want.status) report_mismatch("status", got.status, want.status);
            if (got.bad_arg !== want.bad_arg) report_mismatch("bad_arg", got.bad_arg, want.bad_arg);
            if (want.status != STATUS_OK) error_responses++;
         end
         responses_seen++;
      end
   end

   // ---------------- receiver stall pattern ----------------
   initial begin
      int hold, phase;
      rsp_tready = 1'b0;
      @(negedge reset);
      phase = 0;
      forever begin
         @(posedge clock);
         phase++;
         // one long hold-off while the sender keeps pushing
         if (!long_stall_done && requests_sent > 150) begin
            long_stall_done = 1'b1;
            rsp_tready <= 1'b0;
            for (hold = 0; hold < 300; hold++) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if ((phase / 200) % 3 == 2) begin
            rsp_tready <= 1'b1;   // stall-free stretch
         end else begin
            rsp_tready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // ---------------- sender ----------------
   task automatic send_request(input logic [15:0] mach_in, input logic [15:0] nose_in,
                               input logic [15:0] body_in, input bit typed,
                               input coeff_result_type typed_want);
      coeff_result_type model;
      model = predict_coeff(mach_in, nose_in, body_in);
      req_tvalid <= 1'b1;
      req_tdata  <= {body_in, nose_in, mach_in};
      do @(posedge clock); while (!req_tready);
      // typed rows fix the expectation directly; the predictor covers the rest
      pending_results.push_back(typed ? typed_want : model);
      requests_sent++;
   endtask

   task automatic idle_cycles(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic coeff_result_type err_result(input status_type st, input logic [1:0] arg);
      coeff_result_type r;
      r = '0;
      r.status = st;
      r.bad_arg = arg;
      return r;
   endfunction

   function automatic void add_row(input logic [15:0] m, input logic [15:0] n,
                                   input logic [15:0] b, input bit typed,
                                   input coeff_result_type want);
      stim_row_type row;
      row.mach = m; row.nose = n; row.body = b; row.typed = typed; row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [15:0] rand_fixed();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 1023));    // near unity
         1: return 16'($urandom_range(0, 32767));
         2: return 16'($urandom_range(128, 640));
         default: return 16'($urandom);             // any sign
      endcase
   endfunction

   initial begin
      coeff_result_type none, okay;
      logic [15:0] m, n, b;
      int i, burst;
      none = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      mismatch_count = 0;
      requests_sent = 0;
      responses_seen = 0;
      error_responses = 0;
      long_stall_done = 1'b0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: errors and the M = 1 row typed in, other numeric rows from the predictor
      add_row(16'h8000, 16'h0100, 16'h0100, 1, err_result(STATUS_NEG_ARG, ARG_MACH));
      add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, err_result(STATUS_NEG_ARG, ARG_MACH));
      add_row(16'h0100, 16'h8000, 16'h0100, 1, err_result(STATUS_NEG_ARG, ARG_NOSE));
      add_row(16'h0100, 16'h0100, 16'hFFFF, 1, err_result(STATUS_NEG_ARG, ARG_BODY));
      add_row(16'h0100, 16'h0000, 16'h0100, 1, err_result(STATUS_ZERO_NOSE, ARG_NOSE));
      add_row(16'h0000, 16'h0000, 16'h0000, 1, err_result(STATUS_ZERO_NOSE, ARG_NOSE));
      add_row(16'h0100, 16'h0000, 16'h8000, 1, err_result(STATUS_NEG_ARG, ARG_BODY));
      // M = 1: x1 = 0 (table point 4), x2 = 1 on curve 1
      okay = '0; okay.coeff = 16'd6283; okay.ratio = 16'h0100; okay.status = STATUS_OK;
      add_row(16'h0100, 16'h0100, 16'h0100, 1, okay);
      add_row(16'h0000, 16'h0100, 16'h0000, 0, none);   // M = 0, x1 = -1 clamps low
      add_row(16'h7FFF, 16'h0001, 16'h7FFF, 0, none);   // saturating ratio and axis
      add_row(16'h7FFF, 16'h7FFF, 16'h0000, 0, none);
      add_row(16'h0200, 16'h0100, 16'h0400, 0, none);   // x2 = 4 exactly
      add_row(16'h0200, 16'h0100, 16'h0080, 0, none);   // x2 = 0.5 exactly
      add_row(16'h0200, 16'h0100, 16'h0040, 0, none);   // x2 below range
      add_row(16'h0268, 16'h0100, 16'h0180, 0, none);   // x1 near upper bound
      add_row(16'h0400, 16'h0100, 16'h0200, 0, none);   // x1 beyond upper bound
      add_row(16'h00C0, 16'h0100, 16'h0300, 0, none);   // subsonic
      add_row(16'h0101, 16'h7FFF, 16'h7FFF, 0, none);
      add_row(16'h0180, 16'h0200, 16'h0500, 0, none);
      add_row(16'h0100, 16'h0001, 16'h0000, 0, none);
      foreach (directed_rows[k])
         send_request(directed_rows[k].mach, directed_rows[k].nose, directed_rows[k].body,
                      directed_rows[k].typed, directed_rows[k].want);

      // random part: bursts with random gaps
      i = 0;
      while (i < 1100) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            m = rand_fixed(); n = rand_fixed(); b = rand_fixed();
            if ($urandom_range(0, 9) != 0) begin
               m[15] = 1'b0; n[15] = 1'b0; b[15] = 1'b0;   // mostly valid arguments
            end
            if ($urandom_range(0, 60) == 0) n = 16'h0000;
            send_request(m, n, b, 0, none);
            i++;
         end
         if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("Covered %0d requests (%0d error cases), %0d responses checked.",
               requests_sent, error_responses, responses_seen);
      $display("Input bursts, random gaps, receiver stalls and one long hold-off applied.");
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
